// ===== rtl/quadrature_detent_decoder_assert.svh =====
// Assertion macros for the quadrature detent decoder.
// Used by the top level; expects clk and arst_n in scope.
`ifndef QUADRATURE_DETENT_DECODER_ASSERT_SVH
`define QUADRATURE_DETENT_DECODER_ASSERT_SVH

`ifndef SYNTH
`define QDD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qdd assertion failed");
`define QDD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qdd assertion failed");
`else
`define QDD_ASSERT_IMP(lbl, ante, cons)
`define QDD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/qdd_pkg.sv =====
// Shared types, constants and lookup functions of the quadrature detent decoder.
// No dependencies; compiled first.
package qdd_pkg;

	localparam int OP_W    = 2;
	localparam int PIN_W   = 2;
	localparam int CTL_W   = 16;
	localparam int STEP_W  = 15;
	localparam int SPD_W   = 3;
	localparam int VAL_W   = 16;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 2;
	localparam int PEND_W  = 8;
	localparam int ACC_W   = 4;
	localparam int CHUNK_W = 7;
	localparam int BIT_W   = 3;
	localparam int PROD_W  = 15;

	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
	localparam logic [OP_W-1:0] OP_DRAIN  = 2'd1;
	localparam logic [OP_W-1:0] OP_RESYNC = 2'd2;

	localparam logic [IDX_W-1:0] REG_MODE = 2'd0;
	localparam logic [IDX_W-1:0] REG_STEP = 2'd1;
	localparam logic [IDX_W-1:0] REG_SPD  = 2'd2;
	localparam logic [IDX_W-1:0] REG_CTL  = 2'd3;

	localparam logic signed [PEND_W-1:0] DIR_CAP = 8'sd8;
	localparam logic signed [PEND_W-1:0] REL_CAP = 8'sd127;
	localparam logic [PROD_W-1:0] VALUE_MAX = 15'd32767;
	localparam logic signed [STEP_W-1:0] STEP_MIN = {1'b1, {(STEP_W-1){1'b0}}};
	localparam logic signed [STEP_W-1:0] STEP_FLOOR = STEP_MIN + 15'sd1;

	localparam logic signed [STEP_W-1:0] STEP_RESET = 15'sd1;
	localparam logic [SPD_W-1:0] SPD_RESET = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_CHUNK,
		ST_LOAD
	} qdd_state_t;

	typedef struct packed {
		logic sample;
		logic resync;
		logic drain;
		logic div_step;
		logic chunk;
		logic load;
	} qdd_cmd_t;

	typedef struct packed {
		logic nothing;
		logic relative;
		logic div_done;
		logic last;
		logic out_free;
	} qdd_sts_t;

	function automatic logic [PIN_W-1:0] cw_next(input logic [PIN_W-1:0] p);
		logic [PIN_W-1:0] r;
		case (p)
			2'd0: r = 2'd1;
			2'd1: r = 2'd3;
			2'd2: r = 2'd0;
			default: r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic logic [PIN_W-1:0] ccw_next(input logic [PIN_W-1:0] p);
		logic [PIN_W-1:0] r;
		case (p)
			2'd0: r = 2'd2;
			2'd1: r = 2'd0;
			2'd2: r = 2'd3;
			default: r = 2'd1;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/qdd_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing; payload widths match the package constants.
interface qdd_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [1:0] pin_state;

	modport source (output valid, output operation, output pin_state, input ready);
	modport sink (input valid, input operation, input pin_state, output ready);
endinterface

interface qdd_out_if;
	logic               valid;
	logic               ready;
	logic [15:0]        control_number_out;
	logic               is_relative;
	logic signed [15:0] turn_value;
	logic               last;

	modport source (output valid, output control_number_out, output is_relative,
		output turn_value, output last, input ready);
	modport sink (input valid, input control_number_out, input is_relative,
		input turn_value, input last, output ready);
endinterface

// ===== rtl/qdd_ctrl.sv =====
// Controller state machine: accepts items and sequences the drain work.
// Depends on qdd_pkg for the state, command and status types.
module qdd_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid,
	input  logic [qdd_pkg::OP_W-1:0]    operation,
	output logic                        ready,
	input  qdd_pkg::qdd_sts_t           sts,
	output qdd_pkg::qdd_cmd_t           cmd
);
	import qdd_pkg::*;

	qdd_state_t state_q, state_n;
	logic       take;

	assign take = valid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take && operation == OP_DRAIN && !sts.nothing) begin
					state_n = sts.relative ? ST_DIV : ST_CHUNK;
				end
			end
			ST_DIV: begin
				if (sts.div_done) state_n = ST_CHUNK;
			end
			ST_CHUNK: state_n = ST_LOAD;
			ST_LOAD: begin
				if (sts.out_free) state_n = sts.last ? ST_IDLE : ST_CHUNK;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd   = '0;
		ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ready      = 1'b1;
				cmd.sample = take && operation == OP_SAMPLE;
				cmd.drain  = take && operation == OP_DRAIN;
				cmd.resync = take && operation == OP_RESYNC;
			end
			ST_DIV:   cmd.div_step = 1'b1;
			ST_CHUNK: cmd.chunk = 1'b1;
			ST_LOAD:  cmd.load = sts.out_free;
			default: ;
		endcase
	end

endmodule

// ===== rtl/qdd_dp.sv =====
// Datapath: configuration registers, quadrature decode, detent count,
// bit-serial chunk limit, chunk multiply and output register. Depends on qdd_pkg.
module qdd_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  qdd_pkg::qdd_cmd_t                  cmd,
	output qdd_pkg::qdd_sts_t                  sts,
	input  logic [qdd_pkg::PIN_W-1:0]          pin_state,
	input  logic                               wr_en,
	input  logic [qdd_pkg::IDX_W-1:0]          wr_index,
	input  logic [qdd_pkg::CFG_W-1:0]          wr_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [qdd_pkg::CTL_W-1:0]          control_number_out,
	output logic                               is_relative,
	output logic signed [qdd_pkg::VAL_W-1:0]   turn_value,
	output logic                               last
);
	import qdd_pkg::*;

	logic                      mode_q;
	logic signed [STEP_W-1:0]  step_q;
	logic [SPD_W-1:0]          spd_q;
	logic [CTL_W-1:0]          ctl_q;

	logic [PIN_W-1:0]          prev_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [PEND_W-1:0]  pend_q;
	logic                      init_q;

	logic signed [PEND_W-1:0]  d_q;
	logic [CHUNK_W-1:0]        maxc_q;
	logic [PROD_W-1:0]         prod_q;
	logic [BIT_W-1:0]          bit_q;
	logic signed [VAL_W-1:0]   val_q;
	logic                      last_q;

	logic                      out_valid_q;
	logic signed [VAL_W-1:0]   out_value_q;
	logic                      out_last_q;

	logic [SPD_W-1:0]          spd_eff;
	logic signed [ACC_W:0]     spd_s, acc_x, acc_a, acc_b;
	logic                      up, dn, det_up, det_dn;
	logic signed [PEND_W-1:0]  cap, pend_n, pend_c;
	logic signed [STEP_W-1:0]  step_n, neg_step;
	logic [STEP_W-2:0]         mag;
	logic [20:0]               trial;
	logic                      fit;
	logic signed [PEND_W-1:0]  maxc_s, neg_maxc, chunk, d_next;
	logic signed [22:0]        mul;
	logic signed [VAL_W-1:0]   val_n;

	assign spd_eff = (spd_q == '0) ? 3'd1 : spd_q;
	assign spd_s   = signed'({2'b00, spd_eff});
	assign acc_x   = {acc_q[ACC_W-1], acc_q};
	assign up      = (cw_next(prev_q) == pin_state);
	assign dn      = (ccw_next(prev_q) == pin_state);
	assign acc_a   = acc_x + (up ? 5'sd1 : 5'sd0) - (dn ? 5'sd1 : 5'sd0);
	assign det_up  = (acc_a >= spd_s);
	assign det_dn  = (acc_a <= -spd_s);
	assign acc_b   = det_up ? acc_a - spd_s : (det_dn ? acc_a + spd_s : acc_a);
	assign cap     = mode_q ? REL_CAP : DIR_CAP;

	always_comb begin
		pend_n = pend_q;
		if (det_up && pend_q < cap) pend_n = pend_q + 8'sd1;
		else if (det_dn && pend_q > -cap) pend_n = pend_q - 8'sd1;
	end

	assign pend_c = (pend_q > DIR_CAP) ? DIR_CAP : ((pend_q < -DIR_CAP) ? -DIR_CAP : pend_q);

	assign step_n   = (step_q == STEP_MIN) ? STEP_FLOOR : step_q;
	assign neg_step = -step_n;
	assign mag      = step_n[STEP_W-1] ? neg_step[STEP_W-2:0] : step_n[STEP_W-2:0];
	assign trial    = {6'b0, prod_q} + ({7'b0, mag} << bit_q);
	assign fit      = (trial <= {6'b0, VALUE_MAX});

	assign maxc_s   = signed'({1'b0, maxc_q});
	assign neg_maxc = -maxc_s;
	assign chunk    = (d_q > maxc_s) ? maxc_s : ((d_q < neg_maxc) ? neg_maxc : d_q);
	assign d_next   = d_q - chunk;
	assign mul      = chunk * step_n;
	assign val_n    = mode_q ? mul[VAL_W-1:0] : {{(VAL_W-PEND_W){chunk[PEND_W-1]}}, chunk};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			step_q <= STEP_RESET;
			spd_q  <= SPD_RESET;
			ctl_q  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_MODE: mode_q <= wr_data[0];
				REG_STEP: step_q <= signed'(wr_data[STEP_W-1:0]);
				REG_SPD:  spd_q <= wr_data[SPD_W-1:0];
				REG_CTL:  ctl_q <= wr_data[CTL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			acc_q  <= '0;
			pend_q <= '0;
			init_q <= 1'b0;
		end else if (cmd.resync) begin
			prev_q <= pin_state;
			acc_q  <= '0;
			pend_q <= '0;
			init_q <= 1'b1;
		end else if (cmd.drain) begin
			pend_q <= '0;
		end else if (cmd.sample && init_q) begin
			prev_q <= pin_state;
			acc_q  <= acc_b[ACC_W-1:0];
			pend_q <= pend_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.drain) begin
			d_q    <= mode_q ? pend_q : pend_c;
			maxc_q <= mode_q ? '0 : 7'd1;
			prod_q <= '0;
			bit_q  <= BIT_W'(CHUNK_W - 1);
		end else if (cmd.div_step) begin
			if (fit) begin
				prod_q        <= trial[PROD_W-1:0];
				maxc_q[bit_q] <= 1'b1;
			end
			bit_q <= bit_q - 3'd1;
		end else if (cmd.chunk) begin
			d_q    <= d_next;
			val_q  <= val_n;
			last_q <= (d_next == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_value_q <= val_q;
			out_last_q  <= last_q;
		end
	end

	assign sts.nothing  = (pend_q == '0);
	assign sts.relative = mode_q;
	assign sts.div_done = (bit_q == '0);
	assign sts.last     = last_q;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid          = out_valid_q;
	assign control_number_out = ctl_q;
	assign is_relative        = mode_q;
	assign turn_value         = out_value_q;
	assign last               = out_last_q;

endmodule

// ===== rtl/quadrature_detent_decoder.sv =====
// Top level of the quadrature detent decoder: controller plus datapath.
// Depends on qdd_pkg, qdd_if, qdd_ctrl, qdd_dp and the assertion header.
//
// Usage:
//   item   carries operation (sample, drain, resync) and the two pin levels.
//   result carries control number, mode flag, signed turn value and last.
//   wr_en/wr_index/wr_data write mode, step size, steps per detent and
//   control number; write only while no drain is in progress.
// Samples and resyncs may arrive every clock while no drain is in progress.
// A drain takes the item, then in relative mode finds the chunk limit
// (one quotient bit per cycle), then for each result does a chunk multiply
// and an output load. Direction mode skips the limit search. A drain
// produces 0 to 64 results; no item is taken until its last result is in
// the output register. Samples before the first resync are ignored.
// A stalled receiver holds the output register; while the last result of
// a drain waits, new items are already taken.
// Reset sets config defaults and clears decode and valid state, not data registers.
`include "quadrature_detent_decoder_assert.svh"

module quadrature_detent_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	qdd_in_if.sink                        item,
	qdd_out_if.source                     result,
	input  logic                          wr_en,
	input  logic [qdd_pkg::IDX_W-1:0]     wr_index,
	input  logic [qdd_pkg::CFG_W-1:0]     wr_data
);
	import qdd_pkg::*;

	qdd_cmd_t cmd;
	qdd_sts_t sts;

	qdd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (item.valid),
		.operation (item.operation),
		.ready     (item.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	qdd_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.pin_state          (item.pin_state),
		.wr_en              (wr_en),
		.wr_index           (wr_index),
		.wr_data            (wr_data),
		.out_valid          (result.valid),
		.out_ready          (result.ready),
		.control_number_out (result.control_number_out),
		.is_relative        (result.is_relative),
		.turn_value         (result.turn_value),
		.last               (result.last)
	);

	`QDD_ASSERT_IMP(a_ready_no_work, item.ready, !cmd.chunk && !cmd.div_step && !cmd.load)
	`QDD_ASSERT_NEXT(a_load_valid, cmd.load, result.valid)
	`QDD_ASSERT_NEXT(a_rel_drain_div, cmd.drain && sts.relative && !sts.nothing, cmd.div_step)

endmodule
